FILE: rtl/i2csfr_pkg.sv
`default_nettype none
package i2csfr_pkg;

    typedef enum logic [1:0] {
        MODE_WAIT,
        MODE_ADDR,
        MODE_RECV,
        MODE_SEND
    } bus_mode_t;

    typedef enum logic [1:0] {
        ACK_NONE,
        ACK_PENDING,
        ACK_DRIVE,
        ACK_MASTER
    } ack_phase_t;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_PAYLOAD,
        EV_COMMAND,
        EV_RECONNECT
    } event_t;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SLAVE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE        = 2'd1;

    localparam logic [7:0] CMD_LENGTH = 8'hFF;
    localparam logic [2:0] BIT_MSB    = 3'd7;

    // one sampled bus cycle after edge classification
    typedef struct packed {
        logic       rise;
        logic       fall;
        logic       start;
        logic       sda;
        logic [7:0] status;
    } line_item_t;

    typedef struct packed {
        logic [6:0] slave_address;
        logic       enable;
    } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/i2csfr_front.sv
`default_nettype none
module i2csfr_front
    import i2csfr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic       queue_full,
    output logic            push,
    output line_item_t      item
);

    logic prev_scl_reg;
    logic prev_sda_reg;
    logic scl;
    logic sda;

    assign scl      = s_tdata[0];
    assign sda      = s_tdata[1];
    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        item.rise   = !prev_scl_reg && scl;
        item.fall   = prev_scl_reg && !scl;
        item.start  = prev_sda_reg && !sda && scl;
        item.sda    = sda;
        item.status = s_tdata[9:2];
    end

    // line history follows every transfer, enabled or not
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_scl_reg <= 1'b1;
            prev_sda_reg <= 1'b1;
        end else if (push) begin
            prev_scl_reg <= scl;
            prev_sda_reg <= sda;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/i2csfr_queue.sv
`default_nettype none
module i2csfr_queue
    import i2csfr_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  line_item_t din,
    output logic       full,
    input  wire logic  pop,
    output line_item_t dout,
    output logic       empty
);

    line_item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/i2csfr_back.sv
`default_nettype none
module i2csfr_back
    import i2csfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  cfg_t             cfg,
    input  line_item_t       item,
    input  wire logic        empty,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] sda_drive_low, [8:1] value
    output logic [1:0]       m_tuser,   // [1:0] event_res
    output logic             m_tlast    // last
);

    localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);
    localparam int CMP_W = 9;

    bus_mode_t  mode_reg, mode_next;
    ack_phase_t ack_reg, ack_next;
    logic [7:0] shift_reg, shift_next;
    logic [2:0] bit_reg, bit_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] tx_reg, tx_next;

    logic       out_valid_reg;
    logic       drive_reg, drive_next;
    event_t     ev_reg, ev_next;
    logic [7:0] value_reg, value_next;
    logic       last_reg, last_next;

    logic [7:0] shift_in;
    logic       step;

    assign step     = !empty && (!out_valid_reg || m_tready);
    assign pop      = step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, value_reg, drive_reg};
    assign m_tuser  = ev_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        shift_in          = shift_reg;
        shift_in[bit_reg] = shift_reg[bit_reg] | item.sda;
    end

    always_comb begin
        mode_next  = mode_reg;
        ack_next   = ack_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        tx_next    = tx_reg;
        ev_next    = EV_NONE;
        value_next = 8'd0;
        last_next  = 1'b0;
        drive_next = 1'b0;

        if (!cfg.enable) begin
            mode_next  = MODE_WAIT;
            ack_next   = ACK_NONE;
            shift_next = 8'd0;
            bit_next   = BIT_MSB;
        end else begin
            unique case (mode_reg)
                MODE_WAIT: begin
                    if (item.start) begin
                        mode_next  = MODE_ADDR;
                        ack_next   = ACK_NONE;
                        shift_next = 8'd0;
                        bit_next   = BIT_MSB;
                    end
                end
                MODE_ADDR, MODE_RECV: begin
                    if (ack_reg == ACK_NONE && item.rise) begin
                        shift_next = shift_in;
                        if (bit_reg == 3'd0) begin
                            if (mode_reg == MODE_ADDR) begin
                                if (shift_in[7:1] != cfg.slave_address) begin
                                    mode_next  = MODE_WAIT;
                                    shift_next = 8'd0;
                                    bit_next   = BIT_MSB;
                                end else begin
                                    ack_next = ACK_PENDING;
                                    if (shift_in[0]) begin
                                        mode_next = MODE_SEND;
                                    end
                                end
                            end else begin
                                ack_next = ACK_PENDING;
                            end
                        end else begin
                            bit_next = bit_reg - 3'd1;
                        end
                    end else if (ack_reg == ACK_PENDING && item.fall) begin
                        ack_next = ACK_DRIVE;
                    end else if (ack_reg == ACK_DRIVE && item.fall) begin
                        ack_next   = ACK_NONE;
                        shift_next = 8'd0;
                        bit_next   = BIT_MSB;
                        if (mode_reg == MODE_ADDR) begin
                            mode_next = MODE_RECV;
                            idx_next  = '0;
                        end else if (idx_reg == '0) begin
                            len_next = shift_reg;
                            idx_next = IDX_W'(1);
                        end else if (idx_reg == IDX_W'(1) && len_reg == CMD_LENGTH) begin
                            ev_next    = EV_COMMAND;
                            value_next = shift_reg;
                            mode_next  = MODE_WAIT;
                        end else begin
                            ev_next    = EV_PAYLOAD;
                            value_next = shift_reg;
                            if (CMP_W'(idx_reg) >= CMP_W'(len_reg)) begin
                                last_next = 1'b1;
                                mode_next = MODE_WAIT;
                            end else if (CMP_W'(idx_reg) < CMP_W'(MAX_PAYLOAD)) begin
                                idx_next = idx_reg + IDX_W'(1);
                            end
                        end
                    end
                end
                MODE_SEND: begin
                    if (ack_reg == ACK_PENDING && item.fall) begin
                        ack_next = ACK_DRIVE;
                    end else if (ack_reg == ACK_DRIVE && item.fall) begin
                        tx_next  = item.status;
                        bit_next = BIT_MSB;
                        ack_next = ACK_NONE;
                    end else if (ack_reg == ACK_NONE && item.fall) begin
                        if (bit_reg == 3'd0) begin
                            ack_next = ACK_MASTER;
                        end else begin
                            bit_next = bit_reg - 3'd1;
                        end
                    end else if (ack_reg == ACK_MASTER && item.rise) begin
                        if (item.sda) begin
                            ev_next = EV_RECONNECT;
                        end
                        mode_next  = MODE_WAIT;
                        ack_next   = ACK_NONE;
                        shift_next = 8'd0;
                        bit_next   = BIT_MSB;
                    end
                end
                default: begin
                    mode_next = MODE_WAIT;
                end
            endcase
        end

        if (ack_next == ACK_DRIVE) begin
            drive_next = 1'b1;
        end else if (mode_next == MODE_SEND && ack_next == ACK_NONE) begin
            drive_next = !tx_next[bit_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_WAIT;
            ack_reg   <= ACK_NONE;
            shift_reg <= 8'd0;
            bit_reg   <= BIT_MSB;
            idx_reg   <= '0;
            len_reg   <= 8'd0;
            tx_reg    <= 8'd0;
        end else if (step) begin
            mode_reg  <= mode_next;
            ack_reg   <= ack_next;
            shift_reg <= shift_next;
            bit_reg   <= bit_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            tx_reg    <= tx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            drive_reg <= drive_next;
            ev_reg    <= ev_next;
            value_reg <= value_next;
            last_reg  <= last_next;
        end
    end

    a_disabled_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !cfg.enable |=> out_valid_reg && ev_reg == EV_NONE && !drive_reg)
        else $error("disabled slave produced an event or drove SDA");

    a_command_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        step && ev_next == EV_COMMAND |=> mode_reg == MODE_WAIT)
        else $error("command byte did not end the transfer");

    a_last_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && last_reg |-> ev_reg == EV_PAYLOAD)
        else $error("last flag on a non-payload result");

    a_idx_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(idx_reg) <= CMP_W'(MAX_PAYLOAD))
        else $error("byte index past saturation limit");

endmodule
`default_nettype wire

FILE: rtl/i2c_slave_framed_receiver.sv
// 7-bit I2C slave receiver fed with oversampled bus levels.
// Input stream s_*: one transfer per clock carries the sampled SCL and SDA levels
// and the status byte to return on reads. Output stream m_*: exactly one result
// per input transfer, in order: the SDA pull-down level to apply, an event code
// (tuser: none, payload, command, reconnect), the byte value and tlast on the
// final payload byte of a frame.
// Config channel cfg_*: index 0 = slave address, 1 = enable; always ready.
// Write it only while no results are outstanding.
// An input transfer is first written into the queue; the protocol engine then pops it
// and registers its result in the output register.
// Throughput: one item per cycle sustained while m_tready is high; the front end
// classifies edges, a 2-entry queue feeds the protocol engine, which retires one item
// per cycle into an output register.
// Reset (aresetn low, synchronous) clears the protocol state, disables the slave
// and empties the queue; the line history reads as both lines high.
// When m_tready is low the output register holds; the queue fills, then s_tready
// drops until results are taken again.
`default_nettype none
module i2c_slave_framed_receiver
    import i2csfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [15:0]            s_tdata,   // [0] scl, [1] sda, [9:2] status_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [15:0]                 m_tdata,   // [0] sda_drive_low, [8:1] value
    output logic [1:0]                  m_tuser,   // [1:0] event_res
    output logic                        m_tlast,   // last
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);

    cfg_t       cfg_reg;
    line_item_t front_item;
    line_item_t queue_item;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SLAVE_ADDRESS: cfg_reg.slave_address <= cfg_data[6:0];
                REG_ENABLE:        cfg_reg.enable        <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    i2csfr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (full),
        .push       (push),
        .item       (front_item)
    );

    i2csfr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (front_item),
        .full    (full),
        .pop     (pop),
        .dout    (queue_item),
        .empty   (empty)
    );

    i2csfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .item     (queue_item),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none
module tb_top;
    import i2csfr_pkg::*;

    localparam int PAYLOAD_CAP = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_SAMPLES = 250;

    typedef struct {
        logic       drive;
        event_t     ev;
        logic [7:0] value;
        logic       last;
    } bus_result_t;

    // Tracks the slave's protocol state per accepted line sample and keeps
    // the results it should produce, oldest first.
    class i2c_frame_scoreboard;
        logic [6:0]  slave_addr;
        logic        enabled;
        bus_mode_t   mode;
        ack_phase_t  ack;
        logic [7:0]  shreg;
        logic [2:0]  bitcnt;
        logic [6:0]  byte_idx;
        logic [7:0]  frame_len;
        logic [7:0]  tx;
        logic        prev_scl;
        logic        prev_sda;
        bus_result_t want_q[$];
        int          errors;

        function new();
            slave_addr = 0;
            enabled = 0;
            idle_bus();
            byte_idx = 0;
            frame_len = 0;
            tx = 0;
            prev_scl = 1;
            prev_sda = 1;
            errors = 0;
        endfunction

        function void idle_bus();
            mode = MODE_WAIT;
            shreg = 0;
            bitcnt = BIT_MSB;
            ack = ACK_NONE;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] data);
            if (idx == REG_SLAVE_ADDRESS) begin
                slave_addr = data[6:0];
            end else if (idx == REG_ENABLE) begin
                enabled = data[0];
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void note_sample(logic scl, logic sda, logic [7:0] status);
            bit rise;
            bit fall;
            bus_result_t r;
            rise = (prev_scl == 0) && (scl == 1);
            fall = (prev_scl == 1) && (scl == 0);
            r.drive = 0;
            r.ev = EV_NONE;
            r.value = 0;
            r.last = 0;
            if (!enabled) begin
                idle_bus();
            end else if (mode == MODE_WAIT) begin
                if (prev_sda == 1 && sda == 0 && scl == 1) begin
                    idle_bus();
                    mode = MODE_ADDR;
                end
            end else if (mode == MODE_ADDR || mode == MODE_RECV) begin
                if (ack == ACK_NONE && rise) begin
                    shreg[bitcnt] = shreg[bitcnt] | sda;
                    if (bitcnt == 0) begin
                        if (mode == MODE_ADDR) begin
                            if (shreg[7:1] != slave_addr) begin
                                idle_bus();
                            end else begin
                                ack = ACK_PENDING;
                                if (shreg[0]) mode = MODE_SEND;
                            end
                        end else begin
                            ack = ACK_PENDING;
                        end
                    end else begin
                        bitcnt = bitcnt - 3'd1;
                    end
                end else if (ack == ACK_PENDING && fall) begin
                    ack = ACK_DRIVE;
                end else if (ack == ACK_DRIVE && fall) begin
                    ack = ACK_NONE;
                    if (mode == MODE_ADDR) begin
                        mode = MODE_RECV;
                        byte_idx = 0;
                        shreg = 0;
                        bitcnt = BIT_MSB;
                    end else if (byte_idx == 0) begin
                        // first byte of a write is the frame length
                        frame_len = shreg;
                        byte_idx = 1;
                        shreg = 0;
                        bitcnt = BIT_MSB;
                    end else if (byte_idx == 1 && frame_len == CMD_LENGTH) begin
                        r.ev = EV_COMMAND;
                        r.value = shreg;
                        idle_bus();
                    end else begin
                        r.ev = EV_PAYLOAD;
                        r.value = shreg;
                        if (byte_idx >= frame_len) begin
                            r.last = 1;
                            idle_bus();
                        end else begin
                            if (byte_idx < PAYLOAD_CAP) byte_idx = byte_idx + 7'd1;
                            shreg = 0;
                            bitcnt = BIT_MSB;
                        end
                    end
                end
            end else begin
                if (ack == ACK_PENDING && fall) begin
                    ack = ACK_DRIVE;
                end else if (ack == ACK_DRIVE && fall) begin
                    tx = status;
                    bitcnt = BIT_MSB;
                    ack = ACK_NONE;
                end else if (ack == ACK_NONE && fall) begin
                    if (bitcnt == 0) ack = ACK_MASTER;
                    else bitcnt = bitcnt - 3'd1;
                end else if (ack == ACK_MASTER && rise) begin
                    if (sda) r.ev = EV_RECONNECT;
                    idle_bus();
                end
            end
            if (ack == ACK_DRIVE) begin
                r.drive = 1;
            end else if (mode == MODE_SEND && ack == ACK_NONE) begin
                r.drive = ~tx[bitcnt];
            end
            prev_scl = scl;
            prev_sda = sda;
            want_q.push_back(r);
        endfunction

        function void check_result(logic drive, logic [1:0] ev, logic [7:0] value,
                                   logic last);
            bus_result_t w;
            if (want_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: drive %0b ev %0d value %02h last %0b",
                             drive, ev, value, last);
                return;
            end
            w = want_q.pop_front();
            if (drive !== w.drive || ev !== w.ev || value !== w.value || last !== w.last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at %0t: exp drive %0b ev %0d value %02h last %0b, %s",
                             $realtime, w.drive, w.ev, w.value, w.last,
                             $sformatf("got drive %0b ev %0d value %02h last %0b",
                                       drive, ev, value, last));
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_SLAVE_ADDRESS;
    logic [7:0]  cfg_data = '0;

    i2c_frame_scoreboard sb = new();

    int         in_count = 0;
    int         quiet_cycles = 0;
    int         burst_left = 0;
    int         oversample = 1;
    bit         status_random = 0;
    logic [7:0] status_pin = '0;

    int rx_mode = 0;
    int rx_left = 0;
    int hold_left = 0;
    bit hold_done = 0;

    always #4 aclk = ~aclk;

    i2c_slave_framed_receiver #(.MAX_PAYLOAD(PAYLOAD_CAP)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // transfer monitor: values read here are the ones from before the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_sample(s_tdata[0], s_tdata[1], s_tdata[9:2]);
                in_count++;
            end
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[0], m_tuser, m_tdata[8:1], m_tlast);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side back-pressure; one long hold-off lets the input queue fill
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(16, 160);
        end
        rx_left--;
        if (!hold_done && in_count >= 250) begin
            hold_done = 1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic put_sample(logic scl, logic sda);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, status_pin, sda, scl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // one bus level, held for one or more samples
    task automatic drive_lines(logic scl, logic sda);
        int reps;
        reps = 1;
        if (oversample > 1 && $urandom_range(0, 2) == 0) reps = $urandom_range(2, oversample);
        repeat (reps) begin
            if (status_random) status_pin = 8'($urandom_range(0, 255));
            put_sample(scl, sda);
        end
    endtask

    task automatic send_start();
        drive_lines(1, 1);
        drive_lines(1, 0);
        drive_lines(0, 0);
    endtask

    // eight data clocks plus the acknowledge clock; SDA in the ack slot is noise
    task automatic send_byte(logic [7:0] b);
        logic a;
        for (int i = 7; i >= 0; i--) begin
            drive_lines(0, b[i]);
            drive_lines(1, b[i]);
        end
        a = 1'($urandom_range(0, 1));
        drive_lines(0, a);
        drive_lines(1, a);
    endtask

    task automatic read_status(logic nack);
        logic r;
        repeat (8) begin
            r = 1'($urandom_range(0, 1));
            drive_lines(0, r);
            drive_lines(1, r);
        end
        drive_lines(0, nack);
        drive_lines(1, nack);
    endtask

    // final SCL fall closes the last acknowledge
    task automatic release_bus();
        drive_lines(0, 1);
    endtask

    task automatic write_frame(logic [6:0] addr, logic [7:0] len, int nbytes,
                               logic [7:0] lead);
        send_start();
        send_byte({addr, 1'b0});
        send_byte(len);
        for (int i = 0; i < nbytes; i++) send_byte(i[0] ? ~lead : lead);
        release_bus();
    endtask

    task automatic read_frame(logic [6:0] addr, logic nack);
        send_start();
        send_byte({addr, 1'b1});
        read_status(nack);
        release_bus();
    endtask

    task automatic line_noise(int n);
        repeat (n) drive_lines(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // waiting with no offer lets the monitor note the last input before pending is checked
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(logic [6:0] addr, logic en);
        cfg_valid <= 1'b1;
        cfg_index <= REG_SLAVE_ADDRESS;
        cfg_data <= {1'($urandom_range(0, 1)), addr};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= REG_ENABLE;
        cfg_data <= {7'($urandom_range(0, 127)), en};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_transfer(logic [6:0] addr);
        int kind;
        logic [7:0] len;
        kind = $urandom_range(0, 15);
        if (kind <= 6) begin
            len = 8'($urandom_range(0, 5));
            write_frame(addr, len, (len == 0) ? 1 : len, 8'($urandom_range(0, 255)));
        end else if (kind == 7) begin
            write_frame(addr, CMD_LENGTH, 1, 8'($urandom_range(0, 255)));
        end else if (kind <= 10) begin
            read_frame(addr, 1'($urandom_range(0, 1)));
        end else if (kind <= 12) begin
            write_frame(addr ^ 7'(1 << $urandom_range(0, 6)), 1, 1,
                        8'($urandom_range(0, 255)));
        end else if (kind == 13) begin
            line_noise($urandom_range(2, 12));
        end else if (kind == 14) begin
            // frame cut short; the slave keeps collecting bits from what follows
            len = 8'($urandom_range(2, 8));
            write_frame(addr, len, $urandom_range(0, len - 1), 8'($urandom_range(0, 255)));
        end else begin
            write_frame(addr, 8'($urandom_range(0, 255)), $urandom_range(0, 3),
                        8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int rand_base;
        int n;
        logic [6:0] addr;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // disabled slave ignores the bus but still follows the line levels
        status_random = 1;
        configure(7'h7F, 1'b0);
        line_noise(8);
        settle();

        configure(7'h7F, 1'b1);
        status_random = 0;
        status_pin = 8'h00;
        write_frame(7'h7F, 8'd2, 2, 8'h00);
        write_frame(7'h7F, 8'd0, 1, 8'hA5);
        write_frame(7'h7F, CMD_LENGTH, 1, 8'h5A);
        read_frame(7'h7F, 1'b0);
        status_pin = 8'hFF;
        read_frame(7'h7F, 1'b1);
        write_frame(7'h3F, 8'd1, 1, 8'h11);
        // stray clocks and a stop shape while waiting for a start
        drive_lines(0, 1);
        drive_lines(1, 1);
        drive_lines(0, 0);
        drive_lines(1, 0);
        drive_lines(1, 1);
        write_frame(7'h7F, 8'd1, 1, 8'h3C);
        settle();

        configure(7'h00, 1'b1);
        status_pin = 8'hA5;
        read_frame(7'h00, 1'b1);
        // a frame left open keeps collecting; a repeated start is just more bits
        write_frame(7'h00, 8'd100, 3, 8'h0F);
        send_start();
        send_byte(8'h12);
        release_bus();
        settle();
        configure(7'h00, 1'b0);
        line_noise(6);
        settle();

        status_random = 1;
        rand_base = in_count;
        while (in_count - rand_base < RANDOM_SAMPLES) begin
            case ($urandom_range(0, 5))
                0: addr = 7'h00;
                1: addr = 7'h7F;
                default: addr = 7'($urandom_range(0, 127));
            endcase
            oversample = $urandom_range(1, 3);
            configure(addr, 1'b1);
            n = $urandom_range(3, 8);
            repeat (n) random_transfer(addr);
            settle();
            configure(addr, 1'b0);
            line_noise($urandom_range(4, 12));
            settle();
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
rtl/i2csfr_pkg.sv
rtl/i2csfr_front.sv
rtl/i2csfr_queue.sv
rtl/i2csfr_back.sv
rtl/i2c_slave_framed_receiver.sv
verif/tb_top.sv
